// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for clocked concurrent assertions used by the checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property that is switched off while reset is asserted.
`define ASSERT_CLK(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that is also checked across reset.
`define ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/kct_pkg.sv -----
// ----------------------------------------------------------------------------
// Knob countdown timer package
// Request and result types, event codes, register map and shared constants.
// ----------------------------------------------------------------------------
package kct_pkg;

  // Event codes carried in the op field.
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_CW    = 2'd1;
  localparam logic [1:0] OP_CCW   = 2'd2;
  localparam logic [1:0] OP_PRESS = 2'd3;

  // Configuration register indexes (byte address is four times the index).
  localparam logic [2:0] REG_STREAK_WINDOW = 3'd0;
  localparam logic [2:0] REG_STEP_UNIT     = 3'd1;
  localparam logic [2:0] REG_MAX_STEP      = 3'd2;
  localparam logic [2:0] REG_MAX_DURATION  = 3'd3;
  localparam logic [2:0] REG_MIN_DURATION  = 3'd4;

  localparam int CFG_ADDR_W = 5;

  // Register reset values.
  localparam logic [15:0] STREAK_WINDOW_RST = 16'd300;
  localparam logic [11:0] STEP_UNIT_RST     = 12'd30;
  localparam logic [11:0] MAX_STEP_RST      = 12'd300;
  localparam logic [15:0] MAX_DURATION_RST  = 16'd5939;
  localparam logic [15:0] MIN_DURATION_RST  = 16'd30;

  localparam logic [15:0] DURATION_RST = 16'd300;
  localparam logic [5:0]  STREAK_MAX   = 6'd63;

  // Milliseconds to seconds: x / 1000 == (x * 274877907) >> 38 for any 32-bit x.
  localparam logic [28:0] MS_DIV_MUL   = 29'd274877907;
  localparam int          MS_DIV_SHIFT = 38;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] now_ms;
  } kct_req_t;

  typedef struct packed {
    logic [15:0] remaining_secs;
    logic [15:0] set_duration;
    logic        is_running;
    logic        has_fired;
    logic        changed;
  } kct_rsp_t;

  // Streak count divided by three: (v * 43) >> 7 is exact for v below 128.
  function automatic logic [4:0] streak_div3(input logic [5:0] v);
    logic [12:0] p;
    p = 13'(v) * 13'd43;
    return p[11:7];
  endfunction

endpackage

// ----- hdl/knob_countdown_timer.sv -----
// ----------------------------------------------------------------------------
// Knob countdown timer
// Countdown timer whose duration is set by a rotary knob with acceleration.
// ----------------------------------------------------------------------------
// Timing: an accepted request is first held in the request register; its result
// then goes to the result register, which drives out_valid, once that register can take it.
// Throughput: one request per cycle while the result side is not stalled; the whole
// event is evaluated in one pass between the request register and the result register.
// Reset: synchronous, active low; registers, timer state and handshakes clear.
module knob_countdown_timer
  import kct_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Request channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  kct_req_t              in_data,
  // Result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output kct_rsp_t              out_data,
  // Configuration port
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  // --------------------------------------------------------------------------
  // Configuration registers. Writes complete in the access phase; the port
  // never inserts wait states. Addresses beyond the map are ignored on write
  // and read back as zero.
  // --------------------------------------------------------------------------
  logic [15:0] streak_window_r;
  logic [11:0] step_unit_r;
  logic [11:0] max_step_r;
  logic [15:0] max_duration_r;
  logic [15:0] min_duration_r;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[CFG_ADDR_W-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      streak_window_r <= STREAK_WINDOW_RST;
      step_unit_r     <= STEP_UNIT_RST;
      max_step_r      <= MAX_STEP_RST;
      max_duration_r  <= MAX_DURATION_RST;
      min_duration_r  <= MIN_DURATION_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_STREAK_WINDOW: streak_window_r <= cfg_pwdata[15:0];
        REG_STEP_UNIT:     step_unit_r     <= cfg_pwdata[11:0];
        REG_MAX_STEP:      max_step_r      <= cfg_pwdata[11:0];
        REG_MAX_DURATION:  max_duration_r  <= cfg_pwdata[15:0];
        REG_MIN_DURATION:  min_duration_r  <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_STREAK_WINDOW: cfg_prdata = {16'd0, streak_window_r};
      REG_STEP_UNIT:     cfg_prdata = {20'd0, step_unit_r};
      REG_MAX_STEP:      cfg_prdata = {20'd0, max_step_r};
      REG_MAX_DURATION:  cfg_prdata = {16'd0, max_duration_r};
      REG_MIN_DURATION:  cfg_prdata = {16'd0, min_duration_r};
      default:           cfg_prdata = 32'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Handshake. A request sits in the request register until the result
  // register can take its result; the result register holds a stalled result
  // while the request register already takes the next request.
  // --------------------------------------------------------------------------
  logic     in_valid_r;
  kct_req_t in_req_r;
  logic     out_valid_r;
  kct_rsp_t out_data_r;
  logic     advance;

  assign advance   = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && out_valid_r && out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_req_r <= in_data;
    end
  end

  // --------------------------------------------------------------------------
  // Timer state.
  // --------------------------------------------------------------------------
  logic        running_r,   running_nxt;
  logic        fired_r,     fired_nxt;
  logic [15:0] duration_r,  duration_nxt;
  logic [15:0] remaining_r, remaining_nxt;
  logic [31:0] paused_r,    paused_nxt;
  logic [31:0] start_r,     start_nxt;
  logic [31:0] last_turn_r, last_turn_nxt;
  logic [5:0]  streak_r,    streak_nxt;
  logic        changed;

  // Whole seconds since the last start, by reciprocal multiplication.
  logic [31:0] run_ms;
  logic [60:0] run_prod;
  logic [31:0] run_secs;
  logic [31:0] elapsed;
  logic [15:0] left;

  // Knob step: streak, multiplier and capped step.
  logic [31:0] turn_gap;
  logic [5:0]  streak_new;
  logic [4:0]  mult;
  logic [16:0] step_raw;
  logic [11:0] step;
  logic [16:0] cw_sum;

  assign run_ms   = in_req_r.now_ms - start_r;
  assign run_prod = 61'(run_ms) * 61'(MS_DIV_MUL);
  assign run_secs = 32'(run_prod >> MS_DIV_SHIFT);
  assign elapsed  = run_secs + paused_r;
  assign left     = 16'({16'd0, duration_r} - elapsed);

  assign turn_gap = in_req_r.now_ms - last_turn_r;

  always_comb begin
    // A detent close enough to the previous one extends the streak, which
    // saturates; otherwise the streak starts over.
    if (turn_gap < {16'd0, streak_window_r}) begin
      streak_new = (streak_r < STREAK_MAX) ? streak_r + 6'd1 : streak_r;
    end else begin
      streak_new = 6'd0;
    end
    // One base unit per three streak counts, never less than one unit.
    mult = streak_div3(streak_new);
    if (mult == 5'd0) begin
      mult = 5'd1;
    end
    step_raw = 17'(step_unit_r) * 17'(mult);
    step     = (step_raw > {5'd0, max_step_r}) ? max_step_r : step_raw[11:0];
    cw_sum   = {1'b0, duration_r} + {5'd0, step};
  end

  always_comb begin
    running_nxt   = running_r;
    fired_nxt     = fired_r;
    duration_nxt  = duration_r;
    remaining_nxt = remaining_r;
    paused_nxt    = paused_r;
    start_nxt     = start_r;
    last_turn_nxt = last_turn_r;
    streak_nxt    = streak_r;
    changed       = 1'b0;

    case (in_req_r.op)
      OP_TICK: begin
        // Ticks only matter while counting; reaching the duration fires.
        if (running_r) begin
          if (elapsed >= {16'd0, duration_r}) begin
            running_nxt   = 1'b0;
            remaining_nxt = 16'd0;
            paused_nxt    = {16'd0, duration_r};
            fired_nxt     = 1'b1;
            changed       = 1'b1;
          end else if (left != remaining_r) begin
            remaining_nxt = left;
            changed       = 1'b1;
          end
        end
      end
      OP_CW, OP_CCW: begin
        // The knob is locked out while the timer runs.
        if (!running_r) begin
          streak_nxt    = streak_new;
          last_turn_nxt = in_req_r.now_ms;
          if (in_req_r.op == OP_CW) begin
            duration_nxt = (cw_sum < {1'b0, max_duration_r}) ? cw_sum[15:0]
                                                             : max_duration_r;
          end else if (duration_r > {4'd0, step}) begin
            duration_nxt = duration_r - {4'd0, step};
          end else begin
            // A decrease that would reach zero lands on the minimum.
            duration_nxt = min_duration_r;
          end
          remaining_nxt = duration_nxt;
          paused_nxt    = 32'd0;
          fired_nxt     = 1'b0;
          changed       = 1'b1;
        end
      end
      OP_PRESS: begin
        // Press clears a fired timer, else pauses or (re)starts it.
        changed = 1'b1;
        if (fired_r) begin
          fired_nxt     = 1'b0;
          running_nxt   = 1'b0;
          remaining_nxt = duration_r;
          paused_nxt    = 32'd0;
        end else if (running_r) begin
          paused_nxt  = paused_r + run_secs;
          running_nxt = 1'b0;
        end else begin
          if (remaining_r == 16'd0) begin
            remaining_nxt = duration_r;
            paused_nxt    = 32'd0;
          end
          start_nxt   = in_req_r.now_ms;
          running_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r   <= 1'b0;
      fired_r     <= 1'b0;
      duration_r  <= DURATION_RST;
      remaining_r <= DURATION_RST;
      paused_r    <= 32'd0;
      start_r     <= 32'd0;
      last_turn_r <= 32'd0;
      streak_r    <= 6'd0;
    end else if (advance) begin
      running_r   <= running_nxt;
      fired_r     <= fired_nxt;
      duration_r  <= duration_nxt;
      remaining_r <= remaining_nxt;
      paused_r    <= paused_nxt;
      start_r     <= start_nxt;
      last_turn_r <= last_turn_nxt;
      streak_r    <= streak_nxt;
    end
  end

  // The result shows the state after the event.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r.remaining_secs <= remaining_nxt;
      out_data_r.set_duration   <= duration_nxt;
      out_data_r.is_running     <= running_nxt;
      out_data_r.has_fired      <= fired_nxt;
      out_data_r.changed        <= changed;
    end
  end

endmodule

// ----- hdl/kct_checker.sv -----
// ----------------------------------------------------------------------------
// Knob countdown timer checker
// Port-level assertions on result consistency and the result handshake.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kct_checker
  import kct_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     out_valid,
  input logic     out_stall,
  input kct_rsp_t out_data
);

  // A fired timer is never counting.
  `ASSERT_CLK(a_fired_not_running, clk, rst_n, out_valid |-> !(out_data.is_running && out_data.has_fired), "timer reports running and fired together")

  // A fired timer has no seconds left.
  `ASSERT_CLK(a_fired_zero_left, clk, rst_n, (out_valid && out_data.has_fired) |-> (out_data.remaining_secs == 16'd0), "fired timer shows seconds left")

  // A stalled result stays put.
  `ASSERT_CLK(a_out_hold, clk, rst_n, (out_valid && out_stall) |=> (out_valid && $stable(out_data)), "stalled result changed or dropped")

  // Reset empties the result register.
  `ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result valid right after reset")

endmodule

bind knob_countdown_timer kct_checker u_kct_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
